// File: hdl/kda_pkg.sv
// Shared types and constants for the key debounce and auto-repeat block.
// Used by kda_lane, kda_merge and key_debounce_autorepeat_unit.
package kda_pkg;

   // Number of key slots carried by the payload fields.
   localparam int KeySlots = 8;

   // Configuration register indexes.
   localparam logic [2:0] RegKeyEnable    = 3'd0;
   localparam logic [2:0] RegRepeatEnable = 3'd1;
   localparam logic [2:0] RegFastRepeat   = 3'd2;
   localparam logic [2:0] RegMultEnable   = 3'd3;
   localparam logic [2:0] RegFilterMask   = 3'd4;
   localparam logic [2:0] RegLongDelay    = 3'd5;
   localparam logic [2:0] RegShortDelay   = 3'd6;
   localparam logic [2:0] RegFastAfter    = 3'd7;

   // Register reset values.
   localparam logic [7:0] FilterReset    = 8'd15;
   localparam logic [7:0] LongDelayReset = 8'd50;
   localparam logic [7:0] ShortDelReset  = 8'd10;
   localparam logic [7:0] FastAfterReset = 8'd5;

   localparam logic [7:0] CountMax = 8'hff;

   // Item operation codes.
   localparam logic OpTick  = 1'b0;
   localparam logic OpClear = 1'b1;

   // Settings seen by one lane.
   typedef struct packed {
      logic       key_enable;
      logic       repeat_enable;
      logic       fast_repeat;
      logic       mult_enable;
      logic [7:0] filter_mask;
      logic [7:0] long_delay;
      logic [7:0] short_delay;
      logic [7:0] fast_after;
   } lane_cfg_type;

   // Command broadcast to every lane for one accepted item.
   typedef struct packed {
      logic       fire;
      logic       op;
      logic [2:0] key_index;
   } lane_cmd_type;

   // Flags reported by one lane.
   typedef struct packed {
      logic pressed;
      logic multiply;
   } lane_flags_type;

endpackage

// File: hdl/key_debounce_autorepeat_unit.sv
// Top level of the key debounce and auto-repeat block: settings registers,
// one kda_lane per key and the kda_merge output stage. Depends on kda_pkg.
//
//   Channel | Ports                                           | Direction
//   req     | req_valid req_ready req_op req_raw_keys req_key_index | in
//   rsp     | rsp_valid rsp_ready rsp_pressed_keys rsp_multiply_keys | out
//   csr     | csr_valid csr_ready csr_index csr_wdata         | in
//
// All lanes handle an item together at the edge that accepts it; the merge
// stage then copies the flags into its output register, where the result is
// offered. One item per cycle is taken while the output register is free or
// its result is being taken. Reset is synchronous and restores every lane and
// register to its default.
// A stalled result holds the next item in the lanes; req_ready drops until
// the output register frees up. csr_ready is always high.
module key_debounce_autorepeat_unit import kda_pkg::*; #(
   parameter int KEY_COUNT      = 8,
   parameter int MULTIPLY_AFTER = 10,
   parameter int ACTIVE_LOW     = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_op,
   input  logic [7:0]          req_raw_keys,
   input  logic [2:0]          req_key_index,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [KeySlots-1:0] rsp_pressed_keys,
   output logic [KeySlots-1:0] rsp_multiply_keys,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [7:0]          csr_wdata
);

   localparam int LANES = (KEY_COUNT < KeySlots) ? KEY_COUNT : KeySlots;

   logic [7:0] key_en_ff, rep_en_ff, fast_ff, mult_en_ff;
   logic [7:0] filter_ff, long_ff, short_ff, fast_after_ff;

   logic                        can_accept;
   lane_cmd_type                cmd;
   lane_flags_type [LANES-1:0]  lane_flags;

   assign csr_ready = 1'b1;
   assign req_ready = can_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_en_ff     <= 8'd0;
         rep_en_ff     <= 8'd0;
         fast_ff       <= 8'd0;
         mult_en_ff    <= 8'd0;
         filter_ff     <= FilterReset;
         long_ff       <= LongDelayReset;
         short_ff      <= ShortDelReset;
         fast_after_ff <= FastAfterReset;
      end else if (csr_valid) begin
         case (csr_index)
            RegKeyEnable:    key_en_ff     <= csr_wdata;
            RegRepeatEnable: rep_en_ff     <= csr_wdata;
            RegFastRepeat:   fast_ff       <= csr_wdata;
            RegMultEnable:   mult_en_ff    <= csr_wdata;
            RegFilterMask:   filter_ff     <= csr_wdata;
            RegLongDelay:    long_ff       <= csr_wdata;
            RegShortDelay:   short_ff      <= csr_wdata;
            RegFastAfter:    fast_after_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cmd.fire      = req_valid && can_accept;
   assign cmd.op        = req_op;
   assign cmd.key_index = req_key_index;

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      lane_cfg_type lane_cfg;

      assign lane_cfg.key_enable    = key_en_ff[k];
      assign lane_cfg.repeat_enable = rep_en_ff[k];
      assign lane_cfg.fast_repeat   = fast_ff[k];
      assign lane_cfg.mult_enable   = mult_en_ff[k];
      assign lane_cfg.filter_mask   = filter_ff;
      assign lane_cfg.long_delay    = long_ff;
      assign lane_cfg.short_delay   = short_ff;
      assign lane_cfg.fast_after    = fast_after_ff;

      kda_lane #(
         .LANE_ID        (k),
         .MULTIPLY_AFTER (MULTIPLY_AFTER),
         .ACTIVE_LOW     (ACTIVE_LOW)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .cmd     (cmd),
         .raw_bit (req_raw_keys[k]),
         .cfg     (lane_cfg),
         .flags   (lane_flags[k])
      );
   end

   kda_merge #(
      .LANES (LANES)
   ) u_merge (
      .clock             (clock),
      .reset             (reset),
      .item_fire         (cmd.fire),
      .lane_flags        (lane_flags),
      .can_accept        (can_accept),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pressed_keys  (rsp_pressed_keys),
      .rsp_multiply_keys (rsp_multiply_keys)
   );

endmodule

// File: hdl/kda_lane.sv
// One key lane: history shift, debounce test, repeat timer and press counter.
// Depends on kda_pkg.
module kda_lane import kda_pkg::*; #(
   parameter int LANE_ID        = 0,
   parameter int MULTIPLY_AFTER = 10,
   parameter int ACTIVE_LOW     = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  lane_cmd_type   cmd,
   input  logic           raw_bit,
   input  lane_cfg_type   cfg,
   output lane_flags_type flags
);

   localparam logic [7:0] MultThreshold = 8'(MULTIPLY_AFTER);
   localparam logic [2:0] LaneIndex     = 3'(LANE_ID);

   logic [7:0] hist_ff, hist_in;
   logic [7:0] timer_ff, timer_in;
   logic [7:0] count_ff, count_in;
   logic       pressed_ff, pressed_in;
   logic       mult_ff, mult_in;

   logic [7:0] sel;
   logic       all_set, none_set, is_down, is_up;
   logic [7:0] count_next, timer_load;

   always_comb begin
      hist_in    = {hist_ff[6:0], raw_bit};
      sel        = hist_in & cfg.filter_mask;
      all_set    = (sel == cfg.filter_mask);
      none_set   = (sel == 8'd0);
      // The all-bits test wins over the no-bits test, as with an empty filter.
      if (ACTIVE_LOW == 0) begin
         is_down = all_set;
         is_up   = !all_set && none_set;
      end else begin
         is_up   = all_set;
         is_down = !all_set && none_set;
      end
      if (!cfg.key_enable) begin
         is_down = 1'b0;
         is_up   = 1'b1;
      end

      count_next = (count_ff == CountMax) ? count_ff : count_ff + 8'd1;

      timer_in   = timer_ff;
      count_in   = count_ff;
      pressed_in = pressed_ff;
      mult_in    = mult_ff;
      timer_load = timer_ff;

      if (cmd.fire && cmd.op == OpTick) begin
         if (is_up) begin
            pressed_in = 1'b0;
            mult_in    = 1'b0;
            timer_in   = 8'd0;
            count_in   = 8'd0;
         end else if (is_down) begin
            if (timer_ff == 8'd0) begin
               pressed_in = 1'b1;
               count_in   = count_next;
               timer_load = cfg.long_delay;
               if (count_next > cfg.fast_after && cfg.fast_repeat) begin
                  timer_load = cfg.short_delay;
               end
               if (count_next > MultThreshold && cfg.mult_enable) begin
                  mult_in = 1'b1;
               end
            end
            timer_in = timer_load;
            if (timer_load != 8'd0 && cfg.repeat_enable) begin
               timer_in = timer_load - 8'd1;
            end
         end
      end else if (cmd.fire && cmd.op == OpClear && cmd.key_index == LaneIndex) begin
         pressed_in = 1'b0;
         mult_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff    <= 8'd0;
         timer_ff   <= 8'd0;
         count_ff   <= 8'd0;
         pressed_ff <= 1'b0;
         mult_ff    <= 1'b0;
      end else begin
         if (cmd.fire && cmd.op == OpTick) begin
            hist_ff <= hist_in;
         end
         timer_ff   <= timer_in;
         count_ff   <= count_in;
         pressed_ff <= pressed_in;
         mult_ff    <= mult_in;
      end
   end

   assign flags.pressed  = pressed_ff;
   assign flags.multiply = mult_ff;

endmodule

// File: hdl/kda_merge.sv
// Merging stage: gathers the lane flags into one result item and holds it
// in the output register until taken. Depends on kda_pkg.
module kda_merge import kda_pkg::*; #(
   parameter int LANES = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             item_fire,
   input  lane_flags_type [LANES-1:0]       lane_flags,
   output logic                             can_accept,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [KeySlots-1:0]              rsp_pressed_keys,
   output logic [KeySlots-1:0]              rsp_multiply_keys
);

   logic                pend_ff, pend_in;
   logic                valid_ff, valid_in;
   logic [KeySlots-1:0] pressed_ff, multiply_ff;
   logic [KeySlots-1:0] pressed_vec, multiply_vec;
   logic                load;

   always_comb begin
      pressed_vec  = '0;
      multiply_vec = '0;
      for (int i = 0; i < LANES; i++) begin
         pressed_vec[i]  = lane_flags[i].pressed;
         multiply_vec[i] = lane_flags[i].multiply;
      end
   end

   // The lanes hold an item's outcome until it is copied here, so a new item
   // may enter on the same edge that copies the previous one.
   assign load       = pend_ff && (!valid_ff || rsp_ready);
   assign can_accept = !pend_ff || load;

   always_comb begin
      pend_in  = item_fire ? 1'b1 : (load ? 1'b0 : pend_ff);
      valid_in = load ? 1'b1 : ((valid_ff && rsp_ready) ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pressed_ff  <= pressed_vec;
         multiply_ff <= multiply_vec;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_pressed_keys  = pressed_ff;
   assign rsp_multiply_keys = multiply_ff;

endmodule

// File: sim/kda_flag_checker.sv
`timescale 1ns / 1ps
// Flag checker for key_debounce_autorepeat_unit: tracks register writes, predicts
// the pressed and multiply flags of each item and compares every result.
// Depends on kda_pkg.
module kda_flag_checker import kda_pkg::*; #(
   parameter int KEY_COUNT      = 8,
   parameter int MULTIPLY_AFTER = 10,
   parameter int ACTIVE_LOW     = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                req_op,
   input  logic [7:0]          req_raw_keys,
   input  logic [2:0]          req_key_index,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [KeySlots-1:0] rsp_pressed_keys,
   input  logic [KeySlots-1:0] rsp_multiply_keys,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [7:0]          csr_wdata,
   output int                  open_items,
   output int                  fail_count
);

   typedef enum logic [1:0] {KeyUnsettled, KeyUp, KeyDown} key_level_type;

   typedef struct packed {
      logic [KeySlots-1:0] pressed;
      logic [KeySlots-1:0] multiply;
   } key_flags_type;

   localparam int LiveKeys = (KEY_COUNT < KeySlots) ? KEY_COUNT : KeySlots;

   logic [7:0] enable_bits, repeat_bits, fast_bits, mult_bits;
   logic [7:0] filter_bits, long_ticks, short_ticks, fast_threshold;
   logic [7:0] history [KeySlots];
   logic [7:0] timer [KeySlots];
   logic [7:0] presses [KeySlots];
   logic [KeySlots-1:0] pressed_now, multiply_now;
   key_flags_type flag_forecast [$];
   int errors;

   function automatic key_level_type judge_level(input logic [7:0] hist);
      logic [7:0] sel;
      sel = hist & filter_bits;
      // The all-bits test wins, which matters when the filter is empty.
      if (sel == filter_bits) return (ACTIVE_LOW == 0) ? KeyDown : KeyUp;
      if (sel == 8'd0) return (ACTIVE_LOW == 0) ? KeyUp : KeyDown;
      return KeyUnsettled;
   endfunction

   task automatic scan_keys(input logic [7:0] raw);
      key_level_type level;
      for (int k = 0; k < LiveKeys; k++) begin
         history[k] = {history[k][6:0], raw[k]};
         level = enable_bits[k] ? judge_level(history[k]) : KeyUp;
         if (level == KeyUp) begin
            pressed_now[k] = 1'b0;
            multiply_now[k] = 1'b0;
            timer[k] = 8'd0;
            presses[k] = 8'd0;
         end else if (level == KeyDown) begin
            if (timer[k] == 8'd0) begin
               pressed_now[k] = 1'b1;
               if (presses[k] != CountMax) presses[k] = presses[k] + 8'd1;
               timer[k] = (presses[k] > fast_threshold && fast_bits[k]) ? short_ticks
                                                                        : long_ticks;
               if (int'(presses[k]) > MULTIPLY_AFTER && mult_bits[k])
                  multiply_now[k] = 1'b1;
            end
            if (timer[k] != 8'd0 && repeat_bits[k]) timer[k] = timer[k] - 8'd1;
         end
      end
   endtask

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] seen);
      if (seen !== want) begin
         errors++;
         if (errors <= 10)
            $display("%0t: %s mismatch, expected %02h, got %02h", $realtime, name, want, seen);
      end
   endtask

   always @(posedge clock) begin
      key_flags_type want;
      if (reset) begin
         enable_bits = 8'd0;
         repeat_bits = 8'd0;
         fast_bits = 8'd0;
         mult_bits = 8'd0;
         filter_bits = FilterReset;
         long_ticks = LongDelayReset;
         short_ticks = ShortDelReset;
         fast_threshold = FastAfterReset;
         for (int k = 0; k < KeySlots; k++) begin
            history[k] = 8'd0;
            timer[k] = 8'd0;
            presses[k] = 8'd0;
         end
         pressed_now = '0;
         multiply_now = '0;
         flag_forecast.delete();
         errors = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               RegKeyEnable:    enable_bits = csr_wdata;
               RegRepeatEnable: repeat_bits = csr_wdata;
               RegFastRepeat:   fast_bits = csr_wdata;
               RegMultEnable:   mult_bits = csr_wdata;
               RegFilterMask:   filter_bits = csr_wdata;
               RegLongDelay:    long_ticks = csr_wdata;
               RegShortDelay:   short_ticks = csr_wdata;
               RegFastAfter:    fast_threshold = csr_wdata;
               default: ;
            endcase
         end
         // Results are retired before the item of the same edge is added.
         if (rsp_valid && rsp_ready) begin
            if (flag_forecast.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected result, pressed %02h multiply %02h",
                           $realtime, rsp_pressed_keys, rsp_multiply_keys);
            end else begin
               want = flag_forecast.pop_front();
               compare_field("pressed_keys", want.pressed, rsp_pressed_keys);
               compare_field("multiply_keys", want.multiply, rsp_multiply_keys);
            end
         end
         if (req_valid && req_ready) begin
            if (req_op == OpTick) begin
               scan_keys(req_raw_keys);
            end else begin
               pressed_now[req_key_index] = 1'b0;
               multiply_now[req_key_index] = 1'b0;
            end
            flag_forecast.push_back({pressed_now, multiply_now});
         end
      end
      open_items <= flag_forecast.size();
      fail_count <= errors;
   end

endmodule

// File: sim/key_debounce_autorepeat_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for key_debounce_autorepeat_unit: clock, reset, item and
// register stimulus and the verdict. Depends on kda_pkg and kda_flag_checker.
module key_debounce_autorepeat_unit_tb;
   import kda_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_op = OpTick;
   logic [7:0]          req_raw_keys = 8'd0;
   logic [2:0]          req_key_index = 3'd0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [KeySlots-1:0] rsp_pressed_keys;
   logic [KeySlots-1:0] rsp_multiply_keys;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [2:0]          csr_index = RegKeyEnable;
   logic [7:0]          csr_wdata = 8'd0;
   logic                no_idle = 1'b0;
   int                  open_items;
   int                  fail_count;

   key_debounce_autorepeat_unit dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_op, .req_raw_keys, .req_key_index,
      .rsp_valid, .rsp_ready, .rsp_pressed_keys, .rsp_multiply_keys,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   kda_flag_checker flag_check (
      .clock, .reset,
      .req_valid, .req_ready, .req_op, .req_raw_keys, .req_key_index,
      .rsp_valid, .rsp_ready, .rsp_pressed_keys, .rsp_multiply_keys,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .open_items, .fail_count
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) rsp_ready <= no_idle || ($urandom_range(0, 99) >= 25);

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_item(input logic op, input logic [7:0] raw, input logic [2:0] idx);
      if (!no_idle && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_raw_keys <= raw;
      req_key_index <= idx;
      do @(posedge clock); while (!req_ready);
   endtask

   // Holds off new items until every result has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (open_items != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_settings(input logic [7:0] enable, rep, fast, mult, filter,
                                input logic [7:0] long_d, short_d, fast_after);
      wait_for_results();
      write_reg(RegKeyEnable, enable);
      write_reg(RegRepeatEnable, rep);
      write_reg(RegFastRepeat, fast);
      write_reg(RegMultEnable, mult);
      write_reg(RegFilterMask, filter);
      write_reg(RegLongDelay, long_d);
      write_reg(RegShortDelay, short_d);
      write_reg(RegFastAfter, fast_after);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [7:0] held;
      logic [7:0] raw;
      int sent;
      int span;
      int toggle_odds;
      held = 8'd0;
      sent = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part: disabled keys at reset settings, then a fast-repeating setup
      // that reaches the multiply flag, bouncing input and acknowledges.
      send_item(OpTick, 8'hff, 3'd0);
      send_item(OpClear, 8'h00, 3'd7);
      load_settings(8'hff, 8'hff, 8'hff, 8'hff, 8'h03, 8'd2, 8'd1, 8'd1);
      repeat (14) send_item(OpTick, 8'hff, 3'd0);
      send_item(OpClear, 8'h00, 3'd0);
      send_item(OpClear, 8'h00, 3'd7);
      send_item(OpTick, 8'haa, 3'd2);
      send_item(OpTick, 8'h55, 3'd5);
      send_item(OpTick, 8'h00, 3'd0);
      send_item(OpTick, 8'h00, 3'd0);
      // A clear leaves the history alone even with every raw bit set.
      send_item(OpClear, 8'hff, 3'd5);

      for (int phase = 0; phase < 5 || sent < 1500; phase++) begin
         case (phase)
            0: load_settings(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'd1, 8'd1, 8'd0);
            1: load_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'h00, 8'd0, 8'd0, 8'hff);
            2: load_settings(8'hff, 8'hff, 8'h00, 8'h00, 8'h01, 8'hff, 8'hff, 8'hff);
            3: load_settings(8'hff, 8'hff, 8'($urandom_range(0, 255)), 8'hff, 8'h03,
                             8'd2, 8'd1, 8'd3);
            default:
               load_settings(8'($urandom_range(0, 255) | $urandom_range(0, 255)),
                             8'($urandom_range(0, 255) | $urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                : 32'(8'hff >> $urandom_range(4, 7))),
                             8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                : $urandom_range(0, 6)),
                             8'($urandom_range(0, 4)),
                             8'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                : $urandom_range(0, 12)));
         endcase
         // Phase 3 holds keys down long enough to saturate the press count.
         no_idle <= (phase == 3);
         if (phase == 3) begin
            held = 8'hff;
            toggle_odds = 600;
            span = 400;
         end else begin
            toggle_odds = 30;
            span = $urandom_range(100, 180);
         end
         repeat (span) begin
            if ($urandom_range(0, 7) == 0) begin
               send_item(OpClear, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
            end else begin
               for (int k = 0; k < KeySlots; k++) begin
                  if ($urandom_range(0, toggle_odds - 1) == 0) held[k] = ~held[k];
                  raw[k] = held[k] ^ ($urandom_range(0, 11) == 0);
               end
               if ($urandom_range(0, 19) == 0) raw = 8'($urandom_range(0, 255));
               send_item(OpTick, raw, 3'($urandom_range(0, 7)));
            end
            sent++;
         end
      end

      wait_for_results();
      no_idle <= 1'b0;
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/kda_pkg.sv
hdl/kda_lane.sv
hdl/kda_merge.sv
hdl/key_debounce_autorepeat_unit.sv
sim/kda_flag_checker.sv
sim/key_debounce_autorepeat_unit_tb.sv
